/* sv/dro_pkg.sv */
// Package for the dead-reckoning odometry block: types, constants, angle table.
// Used by every module in sv/.
package dro_pkg;

  localparam int TRIG_ITERATIONS = 16;
  localparam int ITER_W = $clog2(TRIG_ITERATIONS + 1);
  localparam logic signed [33:0] CORDIC_START = 34'sh026DD3B6A;
  localparam logic signed [33:0] Q30_ONE = 34'sh040000000;
  localparam logic [13:0] DIV_BASE = 14'd15625;
  // ceil(2^45 / 15625); x * DIV_RECIP >> 45 is exact for any 32-bit x
  localparam logic [31:0] DIV_RECIP = 32'd2251799814;
  localparam logic [31:0] HALF_BASE = 32'd7812;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PROD, ST_CORDIC,
    ST_MXH, ST_MXL, ST_MYH, ST_MYL, ST_PX, ST_SY, ST_PY,
    ST_DIVA, ST_DIVB, ST_QA, ST_RR, ST_QB, ST_DIVC, ST_FRAC0, ST_FRAC,
    ST_HEAD, ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [63:0] pose_x;
    logic signed [63:0] pose_y;
    logic [31:0]        pose_heading;
    logic signed [15:0] speed_echo;
    logic signed [31:0] rate_echo;
  } result_t;

  typedef struct packed {
    logic [31:0]        timestamp_us;
    logic signed [15:0] linear_speed;
    logic signed [31:0] angular_rate;
  } sample_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] t;
    unique case (i)
      5'd0: t = 32'h20000000;  5'd1: t = 32'h12E4051E;  5'd2: t = 32'h09FB385B;
      5'd3: t = 32'h051111D4;  5'd4: t = 32'h028B0D43;  5'd5: t = 32'h0145D7E1;
      5'd6: t = 32'h00A2F61E;  5'd7: t = 32'h00517C55;  5'd8: t = 32'h0028BE53;
      5'd9: t = 32'h00145F2F;  5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3; 5'd14: t = 32'h0000A2FA;
      5'd15: t = 32'h0000517D; 5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518; 5'd20: t = 32'h0000028C;
      5'd21: t = 32'h00000146; 5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000029; 5'd25: t = 32'h00000014; 5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005; 5'd28: t = 32'h00000003; 5'd29: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

endpackage

/* sv/dro_if.sv */
// Valid/ready channel interfaces for samples, results and the enable register.
// Depends on dro_pkg.
interface dro_sample_if import dro_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dro_result_if import dro_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dro_cfg_if ();
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/dro_cordic.sv */
// Iterative rotation CORDIC: one micro-rotation per cycle, shared adders.
// Gives cos/sin of a binary angle in Q30. Depends on dro_pkg.
module dro_cordic import dro_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [33:0] cos_q30,
  output logic signed [33:0] sin_q30
);
  logic signed [33:0] x, y, x_next, y_next, xs, ys;
  logic signed [32:0] z, z_next;
  logic [ITER_W-1:0]  iter;
  logic               busy, flip;
  logic [31:0]        a0;
  logic signed [33:0] xc, yc;

  assign a0 = (angle[31] ^ angle[30]) ? angle - 32'h80000000 : angle;
  // arithmetic shift is floor division
  assign xs = x >>> iter;
  assign ys = y >>> iter;

  always_comb begin
    if (!z[32]) begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - $signed({1'b0, atan_bam(5'(iter))});
    end else begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + $signed({1'b0, atan_bam(5'(iter))});
    end
    xc = (x > Q30_ONE) ? Q30_ONE : ((x < -Q30_ONE) ? -Q30_ONE : x);
    yc = (y > Q30_ONE) ? Q30_ONE : ((y < -Q30_ONE) ? -Q30_ONE : y);
    cos_q30 = flip ? -xc : xc;
    sin_q30 = flip ? -yc : yc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
        x    <= CORDIC_START;
        y    <= '0;
        z    <= $signed({a0[31], a0});
        flip <= angle[31] ^ angle[30];
      end else if (busy) begin
        x    <= x_next;
        y    <= y_next;
        z    <= z_next;
        iter <= iter + 1'b1;
        if (iter == ITER_W'(TRIG_ITERATIONS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* sv/dro_divider.sv */
// Quotient and remainder of a 32-bit value by 15625, taken from the product
// x * DIV_RECIP made on the shared multiplier. Depends on dro_pkg.
module dro_divider import dro_pkg::*; (
  input  logic [31:0] x,
  input  logic [63:0] recip_prod,
  output logic [18:0] quotient,
  output logic [13:0] remainder
);
  logic [31:0] back;

  assign quotient = recip_prod[63:45];
  assign back = 32'(quotient) * 32'(DIV_BASE);
  assign remainder = 14'(x - back);
endmodule

/* sv/dead_reckoning_odometry_unit.sv */
// Dead-reckoning odometry top level: sequencer, shared 32x32 multiplier, state.
// A new sample is not taken until the previous one is finished: the next sample is
// taken the cycle after the result beat, so any out_ch stall holds off new input.
// The priming sample only records its timestamp and gives no result. Reset (rst,
// synchronous): pose and heading zero, unprimed, enable = 1. Depends on dro_pkg,
// dro_if, dro_cordic and dro_divider.
module dead_reckoning_odometry_unit import dro_pkg::*; (
  input logic           clk,
  input logic           rst,
  dro_sample_if.sink    in_ch,
  dro_result_if.source  out_ch,
  dro_cfg_if.sink       cfg
);
  state_t state, state_next;
  logic        enable, primed;
  logic [31:0] last_ts, heading, dt;
  logic signed [63:0] pos_x, pos_y;
  sample_t     smp;
  logic [46:0] pmag;
  logic signed [33:0] cos_r, sin_r, cos_q, sin_q;
  logic        cd_start, cd_done;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mres_q;
  logic [31:0] vmag, rmag, cmag, smag, frac_op;
  logic [63:0] ma, mb, step_mag;
  logic signed [63:0] step, step_next, sat, pos_sel;
  logic signed [64:0] sum;
  logic        step_neg;
  logic [31:0] dv_x;
  logic [18:0] dv_q, qa, qb;
  logic [13:0] dv_r, ra, rb, rc;
  logic [27:0] prr;
  logic [25:0] acc;
  logic [31:0] dmag;

  assign cfg.ready = 1'b1;
  assign in_ch.ready = (state == ST_IDLE);

  dro_cordic u_cordic (.clk, .rst, .start(cd_start), .angle(heading),
    .done(cd_done), .cos_q30(cos_r), .sin_q30(sin_r));
  dro_divider u_div (.x(dv_x), .recip_prod(mres_q), .quotient(dv_q),
    .remainder(dv_r));

  assign vmag = {16'd0, smp.linear_speed[15] ? 16'(-smp.linear_speed)
                                             : smp.linear_speed};
  assign rmag = smp.angular_rate[31] ? 32'(-smp.angular_rate) : smp.angular_rate;
  assign cmag = cos_q[33] ? 32'(-cos_q) : 32'(cos_q);
  assign smag = sin_q[33] ? 32'(-sin_q) : 32'(sin_q);
  assign frac_op = 32'({rc, 6'd0}) + HALF_BASE;

  // shared 32x32 multiplier, product registered; each state that uses a product
  // consumes the one issued by the state before it
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_PROD, ST_CORDIC: begin
        mul_a = dt;
        mul_b = vmag;
      end
      ST_MXH: begin mul_a = 32'(pmag[46:24]); mul_b = cmag; end
      ST_MXL: begin mul_a = 32'(pmag[23:0]);  mul_b = cmag; end
      ST_MYH: begin mul_a = 32'(pmag[46:24]); mul_b = smag; end
      ST_MYL: begin mul_a = 32'(pmag[23:0]);  mul_b = smag; end
      ST_DIVA: begin mul_a = rmag; mul_b = DIV_RECIP; end
      ST_DIVB: begin mul_a = dt; mul_b = DIV_RECIP; end
      ST_QA: begin mul_a = 32'(qa); mul_b = dt; end
      ST_RR: begin mul_a = 32'(ra); mul_b = 32'(rb); end
      ST_QB: begin mul_a = 32'(ra); mul_b = 32'(qb); end
      ST_DIVC: begin mul_a = 32'(prr); mul_b = DIV_RECIP; end
      ST_FRAC: begin mul_a = frac_op; mul_b = DIV_RECIP; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mres_q <= 64'(mul_a) * 64'(mul_b);
  end

  // value whose reciprocal product sits in mres_q this cycle
  always_comb begin
    unique case (state)
      ST_DIVB:  dv_x = rmag;
      ST_QA:    dv_x = dt;
      ST_FRAC0: dv_x = 32'(prr);
      default:  dv_x = frac_op;
    endcase
  end

  // step = round(pmag*t/2^30) from the hi and lo partial products
  assign step_mag = (ma >> 6) + (({34'd0, ma[5:0], 24'd0} + mb + 64'd536870912) >> 30);
  assign step_neg = smp.linear_speed[15] ^ ((state == ST_MYL) ? cos_q[33] : sin_q[33]);
  assign step_next = step_neg ? -$signed(step_mag) : $signed(step_mag);
  assign pos_sel = (state == ST_PX) ? pos_x : pos_y;
  assign sum = {pos_sel[63], pos_sel} + {step[63], step};
  assign sat = (sum[64] != sum[63]) ? (sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                                    : sum[63:0];

  // q0 = qa*dt + ra*qb + qc kept mod 2^26; dv_q here is the rounded fraction
  assign dmag = {acc, 6'd0} + 32'(dv_q);

  always_comb begin
    state_next = state;
    cd_start = 1'b0;
    unique case (state)
      ST_IDLE:   if (in_ch.valid && primed) begin
        state_next = ST_PROD;
      end
      ST_PROD: begin
        state_next = ST_CORDIC;
        cd_start = 1'b1;
      end
      ST_CORDIC: if (cd_done) state_next = ST_MXH;
      ST_MXH:    state_next = ST_MXL;
      ST_MXL:    state_next = ST_MYH;
      ST_MYH:    state_next = ST_MYL;
      ST_MYL:    state_next = ST_PX;
      ST_PX:     state_next = ST_SY;
      ST_SY:     state_next = ST_PY;
      ST_PY:     state_next = ST_DIVA;
      ST_DIVA:   state_next = ST_DIVB;
      ST_DIVB:   state_next = ST_QA;
      ST_QA:     state_next = ST_RR;
      ST_RR:     state_next = ST_QB;
      ST_QB:     state_next = ST_DIVC;
      ST_DIVC:   state_next = ST_FRAC0;
      ST_FRAC0:  state_next = ST_FRAC;
      ST_FRAC:   state_next = ST_HEAD;
      ST_HEAD:   state_next = enable ? ST_OUT : ST_IDLE;
      ST_OUT:    if (out_ch.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.data = '{pose_x: pos_x, pose_y: pos_y, pose_heading: heading,
    speed_echo: smp.linear_speed, rate_echo: smp.angular_rate};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      enable  <= 1'b1;
      primed  <= 1'b0;
      last_ts <= '0;
      heading <= '0;
      pos_x   <= '0;
      pos_y   <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid) enable <= cfg.data;
      unique case (state)
        ST_IDLE: if (in_ch.valid) begin
          primed  <= 1'b1;
          last_ts <= in_ch.data.timestamp_us;
          dt      <= in_ch.data.timestamp_us - last_ts;
          smp     <= in_ch.data;
        end
        ST_CORDIC: begin
          pmag <= mres_q[46:0];
          if (cd_done) begin
            cos_q <= cos_r;
            sin_q <= sin_r;
          end
        end
        ST_MXL: ma <= mres_q;
        ST_MYH: mb <= mres_q;
        ST_MYL: begin
          step <= step_next;
          ma   <= mres_q;
        end
        ST_PX: begin
          pos_x <= sat;
          mb    <= mres_q;
        end
        ST_SY: step <= step_next;
        ST_PY: pos_y <= sat;
        ST_DIVB: begin
          qa <= dv_q;
          ra <= dv_r;
        end
        ST_QA: begin
          qb <= dv_q;
          rb <= dv_r;
        end
        ST_RR: acc <= mres_q[25:0];
        ST_QB: prr <= mres_q[27:0];
        ST_DIVC: acc <= acc + mres_q[25:0];
        ST_FRAC0: begin
          acc <= acc + 26'(dv_q);
          rc  <= dv_r;
        end
        ST_HEAD: heading <= heading + (smp.angular_rate[31] ? -dmag : dmag);
        default: ;
      endcase
    end
  end
endmodule
